FILE: rtl/lkvc_pkg.sv
// Shared definitions for the LRU key-value cache: default sizes, command
// codes, controller states and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package lkvc_pkg;

  // Default build sizes.
  localparam int DepthDef     = 16;
  localparam int KeyBitsDef   = 16;
  localparam int ValueBitsDef = 32;

  // Capacity register.
  localparam int CapW     = 5;
  localparam int CapReset = 16;

  // Request codes.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WRITE
  } lkvc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch a new request
    logic lookup;   // run the associative search
    logic write;    // commit the update and present the result
  } lkvc_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_get;
  } lkvc_stat_t;

endpackage

FILE: rtl/lkvc_ctrl.sv
// Request sequencer for the LRU key-value cache.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_ctrl import lkvc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  output lkvc_ctrl_t ctrl,
  input  lkvc_stat_t stat
);

  lkvc_state_t state;
  lkvc_state_t state_next;
  logic        accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    busy         = (state == ST_LOOKUP);
    accept       = start && !busy;
    state_next   = state;
    ctrl.capture = accept;
    ctrl.lookup  = 1'b0;
    ctrl.write   = 1'b0;
    done         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        ctrl.lookup = 1'b1;
        state_next  = ST_WRITE;
      end
      ST_WRITE: begin
        // A new request may be taken while this one commits.
        ctrl.write = 1'b1;
        done       = stat.is_get;
        state_next = accept ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/lkvc_datapath.sv
// Entry storage, associative search and recency update for the LRU cache.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_datapath import lkvc_pkg::*; #(
  parameter int DEPTH      = DepthDef,
  parameter int KEY_BITS   = KeyBitsDef,
  parameter int VALUE_BITS = ValueBitsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CapW-1:0]       cfg_wdata,
  input  lkvc_ctrl_t            ctrl,
  output lkvc_stat_t            stat,
  input  logic                  command,
  input  logic [KEY_BITS-1:0]   lookup_key,
  input  logic [VALUE_BITS-1:0] store_value,
  output logic                  found,
  output logic [VALUE_BITS-1:0] read_value
);

  localparam int IdxW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RankW    = IdxW;
  localparam int CntW     = $clog2(DEPTH + 1);
  localparam int CntReset = (CapReset > DEPTH) ? DEPTH : CapReset;

  // Active entry count, saturated to 1..DEPTH.
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_new;
  logic [CntW-1:0] count_m1;

  // Latched request.
  logic                  cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  // Entry state.
  logic [DEPTH-1:0]    valid;
  logic [KEY_BITS-1:0] keys  [DEPTH];
  logic [RankW-1:0]    ranks [DEPTH];
  logic [VALUE_BITS-1:0] value_mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data;

  // Search results, combinational and registered.
  logic            hit_c, free_c;
  logic [IdxW-1:0] hit_idx_c, free_idx_c, vict_idx_c;
  logic [RankW-1:0] hit_rank_c;
  logic            hit_q, free_q;
  logic [IdxW-1:0] slot_q;
  logic [CntW-1:0] old_rank_q;
  logic            wr_value, age_en;

  always_comb begin
    if (cfg_wdata == '0) begin
      count_new = CntW'(1);
    end else if (32'(cfg_wdata) > DEPTH) begin
      count_new = CntW'(DEPTH);
    end else begin
      count_new = CntW'(cfg_wdata);
    end
  end

  assign count_m1 = count - CntW'(1);

  // Lowest-numbered hit and free entry; the victim holds the oldest rank.
  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    vict_idx_c = '0;
    hit_rank_c = '0;
    for (int j = DEPTH - 1; j >= 0; j--) begin
      if (CntW'(j) < count) begin
        if (valid[j] && keys[j] == key_q) begin
          hit_c      = 1'b1;
          hit_idx_c  = IdxW'(j);
          hit_rank_c = ranks[j];
        end
        if (!valid[j]) begin
          free_c     = 1'b1;
          free_idx_c = IdxW'(j);
        end
        if (valid[j] && CntW'(ranks[j]) == count_m1) begin
          vict_idx_c = IdxW'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q <= command;
      key_q <= lookup_key;
      val_q <= store_value;
    end
    if (ctrl.lookup) begin
      rd_data <= value_mem[hit_idx_c];
      hit_q   <= hit_c;
      free_q  <= free_c;
      if (hit_c) begin
        slot_q     <= hit_idx_c;
        old_rank_q <= CntW'(hit_rank_c);
      end else if (free_c) begin
        slot_q     <= free_idx_c;
        old_rank_q <= count;
      end else begin
        slot_q     <= vict_idx_c;
        old_rank_q <= count_m1;
      end
    end
  end

  assign wr_value = ctrl.write && (cmd_q == CMD_PUT);
  assign age_en   = ctrl.write && ((cmd_q == CMD_PUT) || hit_q);

  always_ff @(posedge clk) begin
    if (wr_value) begin
      value_mem[slot_q] <= val_q;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_value && !hit_q) begin
      keys[slot_q] <= key_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CntW'(CntReset);
      valid <= '0;
      for (int j = 0; j < DEPTH; j++) begin
        ranks[j] <= '0;
      end
    end else if (cfg_we) begin
      count <= count_new;
      valid <= '0;
      for (int j = 0; j < DEPTH; j++) begin
        ranks[j] <= '0;
      end
    end else if (age_en) begin
      if (wr_value && !hit_q && free_q) begin
        valid[slot_q] <= 1'b1;
      end
      for (int j = 0; j < DEPTH; j++) begin
        if (IdxW'(j) == slot_q) begin
          ranks[j] <= '0;
        end else if (valid[j] && (CntW'(j) < count) &&
                     (CntW'(ranks[j]) < old_rank_q)) begin
          ranks[j] <= ranks[j] + RankW'(1);
        end
      end
    end
  end

  assign stat.is_get = (cmd_q == CMD_GET);
  assign found       = hit_q;
  assign read_value  = hit_q ? rd_data : '0;

endmodule

FILE: rtl/lru_key_value_cache_unit.sv
// Top level of the LRU key-value cache: sequencer plus datapath.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.
`timescale 1ns / 1ps

//  Channel   Handshake          Payload
//  -------   ----------------   ---------------------------------------
//  request   start / busy       command, lookup_key, store_value
//  result    done (one cycle)   found, read_value
//  config    cfg_we             cfg_wdata (capacity_in_use)
//
// A request transfer takes place at a rising edge with start high and busy
// low. The search runs in the next cycle (busy high), and the update commits
// in the cycle after; a new request may be started in the commit cycle. The
// rate is set by the associative search feeding the registered value-memory
// read ahead of the write-back. A get produces one result with done high for
// exactly one cycle; a put produces none. The receiver cannot stall results.
// Reset (rst, synchronous) empties the cache and sets the capacity to
// CapReset (16), or to DEPTH if that is smaller. There is no clearing pass,
// since valid bits live in flops.

module lru_key_value_cache_unit import lkvc_pkg::*; #(
  parameter int DEPTH      = DepthDef,
  parameter int KEY_BITS   = KeyBitsDef,
  parameter int VALUE_BITS = ValueBitsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CapW-1:0]       cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  logic                  command,
  input  logic [KEY_BITS-1:0]   lookup_key,
  input  logic [VALUE_BITS-1:0] store_value,
  output logic                  done,
  output logic                  found,
  output logic [VALUE_BITS-1:0] read_value
);

  lkvc_ctrl_t ctrl;
  lkvc_stat_t stat;

  // The controller sequences each request through search and commit.
  lkvc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  // The datapath holds the entries and performs the recency update. A
  // capacity write also empties the cache.
  lkvc_datapath #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .ctrl        (ctrl),
    .stat        (stat),
    .command     (command),
    .lookup_key  (lookup_key),
    .store_value (store_value),
    .found       (found),
    .read_value  (read_value)
  );

endmodule
